@@ rtl/sorted_priority_queue_unit_assert.svh @@
// Assertion macros used by the sorted priority queue RTL.
// Each macro expects a clock named i_clk and an active-low reset named i_rst_n in scope.
`ifndef SORTED_PRIORITY_QUEUE_UNIT_ASSERT_SVH
`define SORTED_PRIORITY_QUEUE_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SPQ_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("sorted priority queue assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define SPQ_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("sorted priority queue assertion failed");

`endif

@@ rtl/spq_pkg.sv @@
// Package for the sorted priority queue: field widths, request and status codes,
// default parameter values and the control struct shared by the cell chain.
package spq_pkg;

    localparam int DEPTH_DEFAULT     = 16;
    localparam int PRIO_BITS_DEFAULT = 8;

    localparam int VALUE_W  = 32;
    localparam int PRIO_W   = 8;
    localparam int STATUS_W = 2;
    localparam int HELD_W   = 5;

    typedef enum logic {
        REQ_INSERT = 1'b0,
        REQ_REMOVE = 1'b1
    } t_req;

    typedef enum logic [STATUS_W-1:0] {
        ST_INSERTED  = 2'd0,
        ST_OVERFLOW  = 2'd1,
        ST_REMOVED   = 2'd2,
        ST_UNDERFLOW = 2'd3
    } t_status;

    // Broadcast to every cell for one accepted transaction.
    typedef struct packed {
        logic ins;   // insert that fits: lower entries move one slot down
        logic rem;   // remove from a non-empty queue: entries move one slot up
    } t_shift_cmd;

endpackage

@@ rtl/spq_if.sv @@
// Valid/ready channel interfaces for the sorted priority queue.
// Depends on spq_pkg for the payload widths.
interface spq_req_if import spq_pkg::*; ();
    logic               valid;
    logic               ready;
    logic               req_type;
    logic [VALUE_W-1:0] item_value;
    logic [PRIO_W-1:0]  item_priority;

    modport source (output valid, output req_type, output item_value,
                    output item_priority, input ready);
    modport sink   (input valid, input req_type, input item_value,
                    input item_priority, output ready);
endinterface

interface spq_rsp_if import spq_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [VALUE_W-1:0]  removed_value;
    logic [HELD_W-1:0]   entries_held;

    modport source (output valid, output status, output removed_value,
                    output entries_held, input ready);
    modport sink   (input valid, input status, input removed_value,
                    input entries_held, output ready);
endinterface

@@ rtl/spq_cell.sv @@
// One slot of the sorted queue: holds a value and a priority and takes its
// neighbor's entry on a shift. Depends on spq_pkg.
module spq_cell import spq_pkg::*; #(
    parameter int PRIO_BITS = PRIO_BITS_DEFAULT
) (
    input  logic                 i_clk,
    input  t_shift_cmd           i_cmd,
    input  logic                 i_occupied,
    input  logic                 i_left_lower,
    input  logic [VALUE_W-1:0]   i_left_value,
    input  logic [PRIO_BITS-1:0] i_left_prio,
    input  logic [VALUE_W-1:0]   i_right_value,
    input  logic [PRIO_BITS-1:0] i_right_prio,
    input  logic [VALUE_W-1:0]   i_new_value,
    input  logic [PRIO_BITS-1:0] i_new_prio,
    output logic                 o_lower,
    output logic [VALUE_W-1:0]   o_value,
    output logic [PRIO_BITS-1:0] o_prio
);

    logic [VALUE_W-1:0]   r_value, n_value;
    logic [PRIO_BITS-1:0] r_prio, n_prio;

    // The new entry goes behind this slot when the slot holds an entry of
    // greater or equal priority; otherwise this slot moves down or takes it.
    assign o_lower = !(i_occupied && (r_prio >= i_new_prio));

    always_comb begin
        n_value = r_value;
        n_prio  = r_prio;
        if (i_cmd.ins && o_lower) begin
            if (i_left_lower) begin
                n_value = i_left_value;
                n_prio  = i_left_prio;
            end else begin
                n_value = i_new_value;
                n_prio  = i_new_prio;
            end
        end else if (i_cmd.rem) begin
            n_value = i_right_value;
            n_prio  = i_right_prio;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
        r_prio  <= n_prio;
    end

    assign o_value = r_value;
    assign o_prio  = r_prio;

endmodule

@@ rtl/sorted_priority_queue_unit.sv @@
// Top level of the sorted priority queue: a chain of slot cells, the occupancy
// count and the registered response. Depends on spq_pkg, spq_if and spq_cell.
//
//   channel   direction  payload                                   accepted when
//   i_req     in         req_type, item_value, item_priority       valid && ready
//   o_rsp     out        status, removed_value, entries_held       valid && ready
//
// The response is registered and appears in the cycle after the request is taken.
// Every cell compares its priority with the new one in parallel, so the whole chain
// shifts as one and one request can be taken every cycle unless a response stalls.
// A pending response that is not taken stalls requests; one that is being taken
// does not. Reset empties the queue at once; the slots are not cleared.
module sorted_priority_queue_unit import spq_pkg::*; #(
    parameter int DEPTH     = DEPTH_DEFAULT,
    parameter int PRIO_BITS = PRIO_BITS_DEFAULT
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    spq_req_if.sink   i_req,
    spq_rsp_if.source o_rsp
);

    `include "sorted_priority_queue_unit_assert.svh"

    localparam int OCC_W = $clog2(DEPTH + 1);

    logic [OCC_W-1:0]       r_occ, n_occ;
    logic                   r_out_valid;
    logic [STATUS_W-1:0]    r_status, n_status;
    logic [VALUE_W-1:0]     r_removed, n_removed;
    logic [HELD_W-1:0]      r_held;

    logic                   w_accept;
    logic                   w_full;
    logic                   w_empty;
    logic [PRIO_BITS-1:0]   w_new_prio;
    logic [PRIO_BITS+PRIO_W-1:0] w_prio_ext;
    logic [OCC_W+HELD_W-1:0]     w_held_ext;
    t_shift_cmd             w_cmd;

    logic [DEPTH-1:0]       w_lower;
    logic [VALUE_W-1:0]     w_value [DEPTH];
    logic [PRIO_BITS-1:0]   w_prio  [DEPTH];

    assign i_req.ready = !r_out_valid || o_rsp.ready;
    assign w_accept    = i_req.valid && i_req.ready;
    assign w_full      = (r_occ == OCC_W'(DEPTH));
    assign w_empty     = (r_occ == '0);

    // Keep only the low PRIO_BITS of the priority field, zero-extended if wider.
    assign w_prio_ext = {{PRIO_BITS{1'b0}}, i_req.item_priority};
    assign w_new_prio = w_prio_ext[PRIO_BITS-1:0];

    assign w_cmd.ins = w_accept && (i_req.req_type == REQ_INSERT) && !w_full;
    assign w_cmd.rem = w_accept && (i_req.req_type == REQ_REMOVE) && !w_empty;

    for (genvar k = 0; k < DEPTH; k++) begin : g_cell
        logic                 w_left_lower;
        logic [VALUE_W-1:0]   w_left_value;
        logic [PRIO_BITS-1:0] w_left_prio;
        logic [VALUE_W-1:0]   w_right_value;
        logic [PRIO_BITS-1:0] w_right_prio;

        if (k == 0) begin : g_head
            assign w_left_lower = 1'b0;
            assign w_left_value = '0;
            assign w_left_prio  = '0;
        end else begin : g_body
            assign w_left_lower = w_lower[k-1];
            assign w_left_value = w_value[k-1];
            assign w_left_prio  = w_prio[k-1];
        end

        if (k == DEPTH - 1) begin : g_tail
            assign w_right_value = '0;
            assign w_right_prio  = '0;
        end else begin : g_inner
            assign w_right_value = w_value[k+1];
            assign w_right_prio  = w_prio[k+1];
        end

        spq_cell #(
            .PRIO_BITS (PRIO_BITS)
        ) u_cell (
            .i_clk         (i_clk),
            .i_cmd         (w_cmd),
            .i_occupied    (r_occ > OCC_W'(k)),
            .i_left_lower  (w_left_lower),
            .i_left_value  (w_left_value),
            .i_left_prio   (w_left_prio),
            .i_right_value (w_right_value),
            .i_right_prio  (w_right_prio),
            .i_new_value   (i_req.item_value),
            .i_new_prio    (w_new_prio),
            .o_lower       (w_lower[k]),
            .o_value       (w_value[k]),
            .o_prio        (w_prio[k])
        );
    end

    always_comb begin
        n_occ     = r_occ;
        n_removed = '0;
        if (i_req.req_type == REQ_INSERT) begin
            n_status = w_full ? ST_OVERFLOW : ST_INSERTED;
            if (w_cmd.ins) begin
                n_occ = r_occ + OCC_W'(1);
            end
        end else begin
            n_status = w_empty ? ST_UNDERFLOW : ST_REMOVED;
            if (w_cmd.rem) begin
                n_occ     = r_occ - OCC_W'(1);
                n_removed = w_value[0];
            end
        end
    end

    assign w_held_ext = {{HELD_W{1'b0}}, n_occ};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occ       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_occ <= n_occ;
            end
            if (w_accept) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_status  <= n_status;
            r_removed <= n_removed;
            r_held    <= w_held_ext[HELD_W-1:0];
        end
    end

    assign o_rsp.valid         = r_out_valid;
    assign o_rsp.status        = r_status;
    assign o_rsp.removed_value = r_removed;
    assign o_rsp.entries_held  = r_held;

    `SPQ_ASSERT_NOW(a_occ_bound, 1'b1, r_occ <= OCC_W'(DEPTH))
    `SPQ_ASSERT_NEXT(a_insert_count, w_cmd.ins, r_occ == $past(r_occ) + OCC_W'(1))
    `SPQ_ASSERT_NEXT(a_remove_head, w_cmd.rem,
        (r_status == ST_REMOVED) && (r_removed == $past(w_value[0])))
    `SPQ_ASSERT_NOW(a_zero_unless_removed, r_out_valid && (r_status != ST_REMOVED),
        r_removed == '0)

endmodule

@@ tb/sv/sorted_priority_queue_unit_checker.sv @@
// Checker for the sorted priority queue: watches the request and response channels,
// keeps its own sorted copy of the queue and compares each response with it.
// Depends on spq_pkg and the channel interfaces in spq_if.
module sorted_priority_queue_unit_checker import spq_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    spq_req_if   i_req,
    spq_rsp_if   i_rsp,
    output int   o_fail_count,
    output int   o_outstanding
);

    localparam int QUEUE_DEPTH = DEPTH_DEFAULT;
    localparam int PRIO_USED   = PRIO_BITS_DEFAULT;
    localparam logic [PRIO_W-1:0] PRIO_MASK = PRIO_W'((1 << PRIO_USED) - 1);

    typedef struct packed {
        t_status             status;
        logic [VALUE_W-1:0]  removed_value;
        logic [HELD_W-1:0]   entries_held;
    } t_queue_rsp;

    logic [VALUE_W-1:0] slot_value [QUEUE_DEPTH];
    logic [PRIO_W-1:0]  slot_prio  [QUEUE_DEPTH];
    int unsigned        held_count;

    t_queue_rsp expected_rsp_q [$];

    initial begin
        o_fail_count  = 0;
        o_outstanding = 0;
        held_count    = 0;
    end

    // Applies one request to the shadow queue and returns the response it should cause.
    function automatic t_queue_rsp predict_queue_step(logic kind, logic [VALUE_W-1:0] value,
                                                      logic [PRIO_W-1:0] prio);
        t_queue_rsp        rsp;
        logic [PRIO_W-1:0] prio_m;
        int unsigned       pos;
        rsp.status        = ST_INSERTED;
        rsp.removed_value = '0;
        prio_m            = prio & PRIO_MASK;
        if (kind == REQ_INSERT) begin
            if (held_count >= QUEUE_DEPTH) begin
                rsp.status = ST_OVERFLOW;
            end else begin
                // New entry goes behind every entry of greater or equal priority.
                pos = 0;
                while (pos < held_count && slot_prio[pos] >= prio_m) pos++;
                for (int unsigned k = held_count; k > pos; k--) begin
                    slot_value[k] = slot_value[k-1];
                    slot_prio[k]  = slot_prio[k-1];
                end
                slot_value[pos] = value;
                slot_prio[pos]  = prio_m;
                held_count++;
            end
        end else begin
            if (held_count == 0) begin
                rsp.status = ST_UNDERFLOW;
            end else begin
                rsp.status        = ST_REMOVED;
                rsp.removed_value = slot_value[0];
                for (int unsigned k = 1; k < held_count; k++) begin
                    slot_value[k-1] = slot_value[k];
                    slot_prio[k-1]  = slot_prio[k];
                end
                held_count--;
            end
        end
        rsp.entries_held = HELD_W'(held_count);
        return rsp;
    endfunction

    task automatic report_mismatch(string what, t_queue_rsp want, t_queue_rsp got);
        o_fail_count++;
        if (o_fail_count <= 10) begin
            $display("mismatch at %0t: %s", $realtime, what);
            $display("  expected status=%0d removed=%h held=%0d",
                     want.status, want.removed_value, want.entries_held);
            $display("  actual   status=%0d removed=%h held=%0d",
                     got.status, got.removed_value, got.entries_held);
        end
    endtask

    always @(posedge i_clk) begin
        t_queue_rsp got;
        t_queue_rsp want;
        if (!i_rst_n) begin
            held_count = 0;
            expected_rsp_q.delete();
        end else begin
            if (i_rsp.valid === 1'b1 && i_rsp.ready === 1'b1) begin
                got.status        = t_status'(i_rsp.status);
                got.removed_value = i_rsp.removed_value;
                got.entries_held  = i_rsp.entries_held;
                if (expected_rsp_q.size() == 0) begin
                    want = '0;
                    report_mismatch("response transaction with nothing expected", want, got);
                end else begin
                    want = expected_rsp_q.pop_front();
                    if (got !== want) report_mismatch("response fields differ", want, got);
                end
            end
            if (i_req.valid === 1'b1 && i_req.ready === 1'b1) begin
                expected_rsp_q.push_back(predict_queue_step(i_req.req_type, i_req.item_value,
                                                            i_req.item_priority));
            end
        end
        o_outstanding = expected_rsp_q.size();
    end

endmodule

@@ tb/sv/sorted_priority_queue_unit_tb.sv @@
// Top of the sorted priority queue testbench: clock, reset, request and response
// drivers, and the verdict. Depends on spq_pkg, spq_if, the block and its checker.
module sorted_priority_queue_unit_tb import spq_pkg::*; ();

    localparam int RANDOM_ITEMS = 1380;
    localparam int PAUSE_AT     = 700;
    localparam int QUIET_FROM   = 1230;
    localparam int HOLD_AFTER   = 300;
    localparam int HOLD_CYCLES  = 90;

    logic i_clk;
    logic i_rst_n;
    int   fail_count;
    int   outstanding;
    int   rsp_taken;
    bit   quiet;

    spq_req_if req_bus ();
    spq_rsp_if rsp_bus ();

    sorted_priority_queue_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_bus),
        .o_rsp   (rsp_bus)
    );

    sorted_priority_queue_unit_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_req         (req_bus),
        .i_rsp         (rsp_bus),
        .o_fail_count  (fail_count),
        .o_outstanding (outstanding)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #3_000_000;
        $display("status: fail");
        $finish;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rsp_taken <= 0;
        end else if (rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
            rsp_taken <= rsp_taken + 1;
        end
    end

    // Response side: random stalls, and one long hold-off so the request side backs up.
    initial begin
        bit held_once;
        held_once     = 1'b0;
        rsp_bus.ready = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(negedge i_clk);
            if (!held_once && rsp_taken >= HOLD_AFTER) begin
                held_once     = 1'b1;
                rsp_bus.ready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
            end else if (!quiet && $urandom_range(0, 5) == 0) begin
                rsp_bus.ready = 1'b0;
                repeat ($urandom_range(1, 7)) @(negedge i_clk);
            end
            rsp_bus.ready = 1'b1;
        end
    end

    // Called at a falling edge; returns at the falling edge after the transaction.
    task automatic offer_request(logic kind, logic [VALUE_W-1:0] value,
                                 logic [PRIO_W-1:0] prio);
        if (!quiet && $urandom_range(0, 5) == 0) begin
            req_bus.valid = 1'b0;
            repeat ($urandom_range(1, 7)) @(negedge i_clk);
        end
        req_bus.valid         = 1'b1;
        req_bus.req_type      = kind;
        req_bus.item_value    = value;
        req_bus.item_priority = prio;
        do @(posedge i_clk); while (req_bus.ready !== 1'b1);
        @(negedge i_clk);
    endtask

    function automatic logic [PRIO_W-1:0] pick_priority();
        logic [PRIO_W-1:0] prio;
        case ($urandom_range(0, 3))
            0, 1:    prio = PRIO_W'($urandom_range(0, 255));
            2:       prio = PRIO_W'($urandom_range(0, 3));
            default: prio = PRIO_W'($urandom_range(252, 255));
        endcase
        return prio;
    endfunction

    function automatic logic [VALUE_W-1:0] pick_value();
        logic [VALUE_W-1:0] value;
        case ($urandom_range(0, 9))
            0:       value = 32'h8000_0000;
            1:       value = 32'h7FFF_FFFF;
            2:       value = 32'hFFFF_FFFF;
            3:       value = 32'h0000_0000;
            default: value = $urandom;
        endcase
        return value;
    endfunction

    initial begin
        int  insert_pct;
        int  phase_left;
        logic kind;
        quiet                 = 1'b0;
        req_bus.valid         = 1'b0;
        req_bus.req_type      = REQ_INSERT;
        req_bus.item_value    = '0;
        req_bus.item_priority = '0;
        i_rst_n               = 1'b0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // Directed: remove from empty, extremes, ties in arrival order, full and overflow.
        offer_request(REQ_REMOVE, $urandom, PRIO_W'($urandom));
        offer_request(REQ_INSERT, 32'h7FFF_FFFF, 8'd255);
        offer_request(REQ_INSERT, 32'h8000_0000, 8'd0);
        offer_request(REQ_INSERT, 32'h0000_0000, 8'd128);
        offer_request(REQ_INSERT, 32'h0000_0001, 8'd128);
        offer_request(REQ_INSERT, 32'hFFFF_FFFF, 8'd128);
        offer_request(REQ_REMOVE, $urandom, PRIO_W'($urandom));
        for (int i = 0; i < 12; i++) begin
            offer_request(REQ_INSERT, 32'h0000_1000 + i, PRIO_W'((i * 85) % 256));
        end
        offer_request(REQ_INSERT, 32'hDEAD_BEEF, 8'd255);
        repeat (4) offer_request(REQ_REMOVE, $urandom, PRIO_W'($urandom));

        // Random: phases that lean toward filling, draining, or neither.
        insert_pct = 50;
        phase_left = 0;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (phase_left == 0) begin
                phase_left = $urandom_range(20, 80);
                case ($urandom_range(0, 2))
                    0:       insert_pct = 85;
                    1:       insert_pct = 15;
                    default: insert_pct = 50;
                endcase
            end
            phase_left--;
            if (n == PAUSE_AT) begin
                req_bus.valid = 1'b0;
                while (outstanding != 0) @(negedge i_clk);
            end
            if (n == QUIET_FROM) quiet = 1'b1;
            kind = ($urandom_range(0, 99) < insert_pct) ? REQ_INSERT : REQ_REMOVE;
            offer_request(kind, pick_value(), pick_priority());
        end
        req_bus.valid = 1'b0;

        while (outstanding != 0) @(negedge i_clk);
        repeat (10) @(negedge i_clk);
        if (fail_count == 0 && outstanding == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+rtl
rtl/spq_pkg.sv
rtl/spq_if.sv
rtl/spq_cell.sv
rtl/sorted_priority_queue_unit.sv
tb/sv/sorted_priority_queue_unit_checker.sv
tb/sv/sorted_priority_queue_unit_tb.sv
